[design/midi_byte_stream_assembler_macros.svh]
// Assertion macros used by the top-level design file.
`ifndef MIDI_BYTE_STREAM_ASSEMBLER_MACROS_SVH
`define MIDI_BYTE_STREAM_ASSEMBLER_MACROS_SVH

`ifndef SYNTH
`define MBSA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
`define MBSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define MBSA_ASSERT_IMPL(label, ante, cons)
`define MBSA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[design/mbsa_pkg.sv]
package mbsa_pkg;

  localparam int SYSEX_CAPACITY = 32;

  localparam logic [7:0] RT_MIN      = 8'hF8;
  localparam logic [7:0] SYSEX_OPEN  = 8'hF0;
  localparam logic [7:0] STATUS_BIT  = 8'h80;
  localparam logic [7:0] SYSEX_END   = 8'hF7;

  localparam logic [1:0] SYS_LEN [16] = '{
    2'd0, 2'd2, 2'd3, 2'd2, 2'd0, 2'd0, 2'd1, 2'd0,
    2'd1, 2'd0, 2'd1, 2'd1, 2'd1, 2'd0, 2'd1, 2'd0
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BURST,
    ST_TAIL
  } state_t;

  typedef struct packed {
    logic take;
    logic rd_first;
    logic step;
    logic load_direct;
    logic load_sysex;
    logic load_pend;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic closing;
    logic direct_hit;
    logic burst_end;
    logic pend_hit;
  } sts_t;

  function automatic logic [1:0] status_length(input logic [7:0] s);
    logic [1:0] r;
    if ((s & STATUS_BIT) == 8'h00) begin
      r = 2'd0;
    end else if (s[7:6] == 2'b10) begin
      r = 2'd3;
    end else if (s[7:5] == 3'b110) begin
      r = 2'd2;
    end else if (s[7:4] == 4'b1110) begin
      r = 2'd3;
    end else begin
      r = SYS_LEN[s[3:0]];
    end
    return r;
  endfunction

endpackage

[design/mbsa_controller.sv]
module mbsa_controller (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  mbsa_pkg::sts_t sts,
  output mbsa_pkg::cmd_t cmd
);

  mbsa_pkg::state_t state;
  mbsa_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mbsa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      mbsa_pkg::ST_IDLE: begin
        in_ready = sts.out_free;
        if (in_valid && sts.out_free) begin
          cmd.take = 1'b1;
          if (sts.closing) begin
            cmd.rd_first = 1'b1;
            state_next   = mbsa_pkg::ST_BURST;
          end else begin
            cmd.load_direct = sts.direct_hit;
          end
        end
      end
      mbsa_pkg::ST_BURST: begin
        if (sts.out_free) begin
          cmd.load_sysex = 1'b1;
          if (sts.burst_end) begin
            state_next = sts.pend_hit ? mbsa_pkg::ST_TAIL : mbsa_pkg::ST_IDLE;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      mbsa_pkg::ST_TAIL: begin
        if (sts.out_free) begin
          cmd.load_pend = 1'b1;
          state_next    = mbsa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mbsa_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[design/mbsa_datapath.sv]
module mbsa_datapath #(
  parameter int SYSEX_CAPACITY = mbsa_pkg::SYSEX_CAPACITY
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [7:0]     in_byte,
  input  mbsa_pkg::cmd_t cmd,
  input  logic           out_ready,
  output mbsa_pkg::sts_t sts,
  output logic           out_valid,
  output logic           kind,
  output logic [1:0]     msg_len,
  output logic [7:0]     first_byte,
  output logic [7:0]     second_byte,
  output logic [7:0]     third_byte,
  output logic           last
);

  localparam int AW = $clog2(SYSEX_CAPACITY);
  localparam int CW = $clog2(SYSEX_CAPACITY + 1);
  localparam logic [CW-1:0] CAP    = CW'(SYSEX_CAPACITY);
  localparam logic [CW-1:0] CAP_M1 = CW'(SYSEX_CAPACITY - 1);

  logic [7:0]    running_status;
  logic [1:0]    msg_length;
  logic [1:0]    msg_position;
  logic [7:0]    msg_bytes [3];
  logic [CW-1:0] sysex_count;
  logic [AW-1:0] burst_end_idx;
  logic [AW-1:0] rd_idx;
  logic [7:0]    sysex_store [SYSEX_CAPACITY];
  logic [7:0]    mem_q;

  logic          pend_valid;
  logic [1:0]    pend_len;
  logic [7:0]    pend_b0;
  logic [7:0]    pend_b1;
  logic [7:0]    pend_b2;

  logic          is_rt;
  logic          is_status;
  logic          in_sysex;
  logic          closing;
  logic [1:0]    len_eff;
  logic [1:0]    pos_eff;
  logic [1:0]    pos_after;
  logic [7:0]    bytes_new [3];
  logic          hit;
  logic [7:0]    res_b1;
  logic [7:0]    res_b2;
  logic [CW-1:0] count_m1;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  assign is_rt     = in_byte >= mbsa_pkg::RT_MIN;
  assign is_status = (in_byte & mbsa_pkg::STATUS_BIT) != 8'h00;
  assign in_sysex  = running_status == mbsa_pkg::SYSEX_OPEN;
  assign closing   = !is_rt && in_sysex && is_status;
  assign count_m1  = sysex_count - 1'b1;

  always_comb begin
    len_eff   = is_status ? mbsa_pkg::status_length(in_byte) : msg_length;
    pos_eff   = is_status ? 2'd0 : msg_position;
    bytes_new = msg_bytes;
    pos_after = pos_eff;
    if (len_eff != 2'd0 && pos_eff != 2'd3) begin
      bytes_new[pos_eff] = in_byte;
      pos_after          = pos_eff + 2'd1;
    end
    hit    = (len_eff != 2'd0) && (pos_after >= len_eff);
    res_b1 = (len_eff >= 2'd2) ? bytes_new[1] : 8'h00;
    res_b2 = (len_eff >= 2'd3) ? bytes_new[2] : 8'h00;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = sysex_count[AW-1:0];
    wr_data = in_byte;
    if (cmd.take && !is_rt) begin
      if (in_sysex && !is_status && sysex_count < CAP_M1) begin
        wr_en = 1'b1;
      end else if (closing && sysex_count < CAP) begin
        wr_en   = 1'b1;
        wr_data = mbsa_pkg::SYSEX_END;
      end else if (!in_sysex && in_byte == mbsa_pkg::SYSEX_OPEN) begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = mbsa_pkg::SYSEX_OPEN;
      end
    end
  end

  assign rd_en   = cmd.rd_first || cmd.step;
  assign rd_addr = cmd.rd_first ? '0 : AW'(rd_idx + 1'b1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      sysex_store[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= sysex_store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_idx <= rd_addr;
    end
    if (cmd.take && closing) begin
      burst_end_idx <= (sysex_count < CAP) ? sysex_count[AW-1:0] : count_m1[AW-1:0];
      pend_len      <= len_eff;
      pend_b0       <= bytes_new[0];
      pend_b1       <= res_b1;
      pend_b2       <= res_b2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_status <= '0;
      msg_length     <= '0;
      msg_position   <= '0;
      msg_bytes      <= '{default: '0};
      sysex_count    <= '0;
      pend_valid     <= 1'b0;
    end else if (cmd.take && !is_rt) begin
      if (is_status) begin
        running_status <= in_byte;
      end
      msg_length   <= len_eff;
      msg_position <= hit ? 2'd1 : pos_after;
      msg_bytes    <= bytes_new;
      if (is_status && in_byte == mbsa_pkg::SYSEX_OPEN) begin
        sysex_count <= CW'(1);
      end else if (in_sysex && !is_status && sysex_count < CAP_M1) begin
        sysex_count <= sysex_count + 1'b1;
      end else if (closing && sysex_count < CAP) begin
        sysex_count <= sysex_count + 1'b1;
      end
      if (closing) begin
        pend_valid <= hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_direct || cmd.load_sysex || cmd.load_pend) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_direct) begin
      kind        <= 1'b0;
      last        <= 1'b1;
      msg_len     <= is_rt ? 2'd1 : len_eff;
      first_byte  <= is_rt ? in_byte : bytes_new[0];
      second_byte <= is_rt ? 8'h00 : res_b1;
      third_byte  <= is_rt ? 8'h00 : res_b2;
    end else if (cmd.load_sysex) begin
      kind        <= 1'b1;
      last        <= sts.burst_end && !pend_valid;
      msg_len     <= 2'd1;
      first_byte  <= mem_q;
      second_byte <= 8'h00;
      third_byte  <= 8'h00;
    end else if (cmd.load_pend) begin
      kind        <= 1'b0;
      last        <= 1'b1;
      msg_len     <= pend_len;
      first_byte  <= pend_b0;
      second_byte <= pend_b1;
      third_byte  <= pend_b2;
    end
  end

  assign sts.out_free   = !out_valid || out_ready;
  assign sts.closing    = closing;
  assign sts.direct_hit = is_rt || hit;
  assign sts.burst_end  = rd_idx == burst_end_idx;
  assign sts.pend_hit   = pend_valid;

endmodule

[design/midi_byte_stream_assembler.sv]
// A short or realtime message is on the output in the cycle after its byte is taken.
// Throughput: one byte per cycle while the output register drains each cycle.
// A status byte that closes a system exclusive message streams the buffer from the
// store one byte per cycle while the output drains, then any short message; input waits meanwhile.
// Reset (rst, synchronous): clears running status, message state, counts and valid flags.
// The system exclusive store is not cleared; only written entries are ever read.
`include "midi_byte_stream_assembler_macros.svh"

module midi_byte_stream_assembler #(
  parameter int SYSEX_CAPACITY = mbsa_pkg::SYSEX_CAPACITY
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       kind,
  output logic [1:0] msg_len,
  output logic [7:0] first_byte,
  output logic [7:0] second_byte,
  output logic [7:0] third_byte,
  output logic       last
);

  mbsa_pkg::cmd_t cmd;
  mbsa_pkg::sts_t sts;

  mbsa_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mbsa_datapath #(
    .SYSEX_CAPACITY (SYSEX_CAPACITY)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_byte     (in_byte),
    .cmd         (cmd),
    .out_ready   (out_ready),
    .sts         (sts),
    .out_valid   (out_valid),
    .kind        (kind),
    .msg_len     (msg_len),
    .first_byte  (first_byte),
    .second_byte (second_byte),
    .third_byte  (third_byte),
    .last        (last)
  );

  `MBSA_ASSERT_IMPL(a_ready_needs_room, in_ready, !out_valid || out_ready)
  `MBSA_ASSERT_IMPL(a_no_take_mid_burst, out_valid && kind && !last, !in_ready)
  `MBSA_ASSERT_NEXT(a_close_stalls_input, in_valid && in_ready && sts.closing, !in_ready)

endmodule
